FILE: hdl/sprite_camera_projection_core_assert.svh
// assertion macros for the sprite projection checker
// no dependencies; included by the checker file
`ifndef SPRITE_CAMERA_PROJECTION_CORE_ASSERT_SVH
`define SPRITE_CAMERA_PROJECTION_CORE_ASSERT_SVH

// clocked assertion, masked while reset is held
`define SCP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/scp_pkg.sv
// shared types and constants for the sprite camera projection core
// no dependencies
package scp_pkg;

    localparam int RES_W = 13;
    localparam logic [RES_W-1:0] RES_MAX = 13'd4096;
    localparam logic [RES_W-1:0] RES_MIN = 13'd1;
    localparam logic [RES_W-1:0] WIDTH_RST = 13'd640;
    localparam logic [RES_W-1:0] HEIGHT_RST = 13'd480;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    // one quotient bit per stage, depth quotient is the widest
    localparam int DIV_STAGES = 32;

    localparam int IN_TDATA_W = 256;
    localparam int OUT_TDATA_W = 128;

    typedef struct packed {
        logic det_zero;
        logic ny_zero;
        logic nx_neg;
        logic depth_neg;
        logic center_neg;
    } t_side;

    // first member ends up in the high bits
    typedef struct packed {
        logic [11:0]        last_row;
        logic [11:0]        first_row;
        logic signed [15:0] last_column;
        logic signed [15:0] first_column;
        logic [15:0]        sprite_size;
        logic signed [15:0] center_column;
        logic               visible;
        logic signed [31:0] depth;
    } t_result;

    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(t_result);

endpackage

FILE: hdl/scp_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// no dependencies
module scp_div #(
    parameter int NW     = 8,
    parameter int DW     = 8,
    parameter int QBITS  = 4,
    parameter int STAGES = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NW-1:0]    i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QBITS-1:0] o_quo,
    output logic             o_ovf
);

    localparam int CW = ((NW > DW) ? NW : DW) + QBITS + 1;

    logic [CW-1:0]    r_rem [0:STAGES];
    logic [DW-1:0]    r_den [0:STAGES];
    logic [QBITS-1:0] r_quo [0:STAGES];
    logic             r_ovf [0:STAGES];

    // quotient does not fit when num >= den * 2^QBITS (also catches den of zero)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (CW'(i_num) >= (CW'(i_den) << QBITS));
        end
    end

    for (genvar k = 1; k <= STAGES; k++) begin : g_stage
        localparam int BI = STAGES - k;
        if (BI < QBITS) begin : g_step
            logic [CW:0] w_diff;
            assign w_diff = {1'b0, r_rem[k-1]} - {1'b0, (CW'(r_den[k-1]) << BI)};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= r_den[k-1];
                    r_ovf[k] <= r_ovf[k-1];
                    if (!w_diff[CW]) begin
                        r_rem[k] <= w_diff[CW-1:0];
                        r_quo[k] <= r_quo[k-1] | (QBITS'(1) << BI);
                    end else begin
                        r_rem[k] <= r_rem[k-1];
                        r_quo[k] <= r_quo[k-1];
                    end
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                    r_quo[k] <= r_quo[k-1];
                    r_ovf[k] <= r_ovf[k-1];
                end
            end
        end
    end

    assign o_quo = r_quo[STAGES];
    assign o_ovf = r_ovf[STAGES];

endmodule

FILE: hdl/sprite_camera_projection_core.sv
// top level of the sprite camera projection core
// depends on scp_pkg and scp_div
//
// Projects one sprite per beat into screen space for a raycasting renderer.
// Each input beat carries the sprite position and the player position, view
// direction and camera plane in signed fixed point (FRAC_BITS fraction bits).
// The core takes one beat every clock while s_axis_tready is high and returns
// one result beat per input beat, in order. Most of the pipeline depth is the
// division chain: three restoring dividers (depth, centre column, sprite size)
// run side by side and retire one quotient bit per pipeline stage, 32 stages
// for the 32-bit depth, with six stages of subtract/multiply ahead of them and
// two clamp stages behind. An output register with a one-beat skid stage sits
// at the end; while the skid holds a beat, s_axis_tready is low and the whole
// pipeline holds. The user must write screen_width and screen_height through
// the cfg port only while no beat is in flight; the core does not enforce it.
// 0 reads as 1 and anything above 4096 as 4096.
module sprite_camera_projection_core
    import scp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [RES_W-1:0]        i_cfg_wdata,
    // input stream
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // tdata: sprite_x, sprite_y, player_x, player_y, dir_x, dir_y, plane_x,
    // plane_y, 32 bits each from the lowest bit up
    input  logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // output stream
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // tdata: depth[31:0], visible[32], center_column[48:33], sprite_size[64:49],
    // first_column[80:65], last_column[96:81], first_row[108:97],
    // last_row[120:109], zeros above
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    // widths of the intermediate terms
    localparam int DN_W  = 66 + FRAC_BITS;   // |ny| << FRAC_BITS
    localparam int NSTG  = 6 + 1 + DIV_STAGES + 2;

    // ---------------------------------------------------------------- config
    logic [RES_W-1:0] r_width;
    logic [RES_W-1:0] r_height;
    logic [RES_W-1:0] w_width_eff;
    logic [RES_W-1:0] w_height_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_wdata;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // out-of-range resolutions fold into 1..4096
    always_comb begin
        w_width_eff  = r_width;
        w_height_eff = r_height;
        if (r_width < RES_MIN)  w_width_eff  = RES_MIN;
        if (r_width > RES_MAX)  w_width_eff  = RES_MAX;
        if (r_height < RES_MIN) w_height_eff = RES_MIN;
        if (r_height > RES_MAX) w_height_eff = RES_MAX;
    end

    // ------------------------------------------------------- flow control
    logic            w_en;
    logic            w_out_ready;
    logic [NSTG-1:0] r_vld;
    logic            r_out_valid;
    logic            r_skid_valid;
    t_result         r_out_data;
    t_result         r_skid_data;
    t_result         r_p2;

    // pipeline advances whenever the skid stage is free
    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en;
    assign w_out_ready     = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_axis_tvalid};
        end
    end

    // output register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= r_vld[NSTG-1];
            end
        end else if (w_en && r_vld[NSTG-1]) begin
            // output is stuck, park the tail beat
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_out_data <= r_skid_valid ? r_skid_data : r_p2;
        end else if (w_en) begin
            r_skid_data <= r_p2;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_data};

    // ------------------------------------------------ stage 1: relative pos
    logic signed [31:0] w_sx, w_sy, w_px, w_py, w_dx, w_dy, w_plx, w_ply;
    assign w_sx  = i_s_axis_tdata[31:0];
    assign w_sy  = i_s_axis_tdata[63:32];
    assign w_px  = i_s_axis_tdata[95:64];
    assign w_py  = i_s_axis_tdata[127:96];
    assign w_dx  = i_s_axis_tdata[159:128];
    assign w_dy  = i_s_axis_tdata[191:160];
    assign w_plx = i_s_axis_tdata[223:192];
    assign w_ply = i_s_axis_tdata[255:224];

    logic signed [32:0] r1_rx, r1_ry;
    logic signed [31:0] r1_dx, r1_dy, r1_plx, r1_ply;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_rx  <= 33'(w_sx) - 33'(w_px);
            r1_ry  <= 33'(w_sy) - 33'(w_py);
            r1_dx  <= w_dx;
            r1_dy  <= w_dy;
            r1_plx <= w_plx;
            r1_ply <= w_ply;
        end
    end

    // ---------------------------------------------------- stage 2: products
    logic signed [64:0] r2_dyrx, r2_dxry, r2_plxry, r2_plyrx;
    logic signed [63:0] r2_plxdy, r2_dxply;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dyrx  <= r1_dy * r1_rx;
            r2_dxry  <= r1_dx * r1_ry;
            r2_plxry <= r1_plx * r1_ry;
            r2_plyrx <= r1_ply * r1_rx;
            r2_plxdy <= r1_plx * r1_dy;
            r2_dxply <= r1_dx * r1_ply;
        end
    end

    // ------------------------------------- stage 3: camera-space numerators
    logic signed [65:0] r3_nx, r3_ny;
    logic signed [63:0] r3_det;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_nx  <= 66'(r2_dyrx) - 66'(r2_dxry);
            r3_ny  <= 66'(r2_plxry) - 66'(r2_plyrx);
            // determinant wraps at 64 bits
            r3_det <= r2_plxdy - r2_dxply;
        end
    end

    // ------------------------------------------ stage 4: nx+ny and det*H
    logic signed [66:0] r4_sum;
    logic signed [77:0] r4_dh;
    logic signed [65:0] r4_ny;
    logic signed [63:0] r4_det;
    logic               r4_nx_neg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sum    <= 67'(r3_nx) + 67'(r3_ny);
            r4_dh     <= r3_det * $signed({1'b0, w_height_eff});
            r4_ny     <= r3_ny;
            r4_det    <= r3_det;
            r4_nx_neg <= r3_nx[65];
        end
    end

    // ---------------------------------------- stage 5: (nx+ny) * (W/2)
    logic signed [79:0] r5_cnum;
    logic signed [77:0] r5_dh;
    logic signed [65:0] r5_ny;
    logic signed [63:0] r5_det;
    logic               r5_nx_neg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_cnum   <= r4_sum * $signed({1'b0, w_width_eff[RES_W-1:1]});
            r5_dh     <= r4_dh;
            r5_ny     <= r4_ny;
            r5_det    <= r4_det;
            r5_nx_neg <= r4_nx_neg;
        end
    end

    // -------------------------------------- stage 6: magnitudes and signs
    logic [65:0] r6_ny_mag;
    logic [63:0] r6_det_mag;
    logic [77:0] r6_cnum_mag;
    logic [75:0] r6_dh_mag;
    t_side       r6_side;
    logic [79:0] w_cnum_abs;
    logic [77:0] w_dh_abs;

    assign w_cnum_abs = r5_cnum[79] ? 80'(-r5_cnum) : 80'(r5_cnum);
    assign w_dh_abs   = r5_dh[77] ? 78'(-r5_dh) : 78'(r5_dh);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_ny_mag            <= r5_ny[65] ? 66'(-r5_ny) : 66'(r5_ny);
            r6_det_mag           <= r5_det[63] ? 64'(-r5_det) : 64'(r5_det);
            r6_cnum_mag          <= w_cnum_abs[77:0];
            r6_dh_mag            <= w_dh_abs[75:0];
            r6_side.det_zero     <= (r5_det == '0);
            r6_side.ny_zero      <= (r5_ny == '0);
            r6_side.nx_neg       <= r5_nx_neg;
            r6_side.depth_neg    <= r5_ny[65] ^ r5_det[63];
            r6_side.center_neg   <= r5_cnum[79] ^ r5_ny[65];
        end
    end

    // ------------------------------------------------------------ dividers
    logic [31:0] w_qd;
    logic [16:0] w_qc;
    logic [15:0] w_qs;
    logic        w_ovf_d, w_ovf_c, w_ovf_s;

    // depth = ny * 2^FRAC_BITS / det
    scp_div #(
        .NW(DN_W), .DW(64), .QBITS(32), .STAGES(DIV_STAGES)
    ) u_div_depth (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r6_ny_mag, {FRAC_BITS{1'b0}}}),
        .i_den (r6_det_mag),
        .o_quo (w_qd),
        .o_ovf (w_ovf_d)
    );

    // centre = (W/2) * (nx + ny) / ny
    scp_div #(
        .NW(78), .DW(66), .QBITS(17), .STAGES(DIV_STAGES)
    ) u_div_center (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_cnum_mag),
        .i_den (r6_ny_mag),
        .o_quo (w_qc),
        .o_ovf (w_ovf_c)
    );

    // size = |H * det| / |ny|
    scp_div #(
        .NW(76), .DW(66), .QBITS(16), .STAGES(DIV_STAGES)
    ) u_div_size (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_dh_mag),
        .i_den (r6_ny_mag),
        .o_quo (w_qs),
        .o_ovf (w_ovf_s)
    );

    // flags ride alongside the divider stages
    t_side r_side [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r6_side;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------------------------------- post stage 1: saturation
    t_side              w_sd;
    logic signed [31:0] n_depth;
    logic signed [15:0] n_center;
    logic [15:0]        n_size;
    logic signed [31:0] r_p1_depth;
    logic signed [15:0] r_p1_center;
    logic [15:0]        r_p1_size;
    logic               r_p1_visible;

    assign w_sd = r_side[DIV_STAGES];

    always_comb begin
        // depth, zero for a singular camera
        if (w_sd.det_zero) begin
            n_depth = '0;
        end else if (!w_sd.depth_neg) begin
            n_depth = (w_ovf_d || w_qd[31]) ? 32'sh7fff_ffff : $signed(w_qd);
        end else if (w_ovf_d || (w_qd > 32'h8000_0000)) begin
            n_depth = 32'sh8000_0000;
        end else begin
            n_depth = $signed(32'(0 - w_qd));
        end

        // centre column, pinned to an edge when ny is zero
        if (w_sd.ny_zero) begin
            n_center = w_sd.nx_neg ? 16'sh8000 : 16'sh7fff;
        end else if (!w_sd.center_neg) begin
            n_center = (w_ovf_c || w_qc > 17'd32767) ? 16'sh7fff : $signed(w_qc[15:0]);
        end else if (w_ovf_c || (w_qc > 17'd32768)) begin
            n_center = 16'sh8000;
        end else begin
            n_center = $signed(16'(17'd0 - w_qc));
        end

        n_size = (w_sd.ny_zero || w_ovf_s) ? 16'hffff : w_qs;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_depth   <= n_depth;
            r_p1_visible <= !n_depth[31] && (n_depth != '0);
            r_p1_center  <= n_center;
            r_p1_size    <= n_size;
        end
    end

    // ------------------------------------------- post stage 2: bounds
    logic [14:0]        w_half;
    logic [11:0]        w_h_half;
    logic [15:0]        w_lr_raw;
    logic signed [16:0] w_fc_raw;
    logic signed [16:0] w_lc_raw;
    t_result            n_res;

    assign w_half   = r_p1_size[15:1];
    assign w_h_half = w_height_eff[12:1];
    assign w_lr_raw = 16'(w_half) + 16'(w_h_half);
    assign w_fc_raw = 17'(r_p1_center) - $signed({2'b00, w_half});
    assign w_lc_raw = 17'(r_p1_center) + $signed({2'b00, w_half});

    always_comb begin
        n_res.depth         = r_p1_depth;
        n_res.visible       = r_p1_visible;
        n_res.center_column = r_p1_center;
        n_res.sprite_size   = r_p1_size;

        if (15'(w_h_half) > w_half) begin
            n_res.first_row = 12'(15'(w_h_half) - w_half);
        end else begin
            n_res.first_row = '0;
        end

        if (w_lr_raw >= 16'(w_height_eff)) begin
            n_res.last_row = 12'(w_height_eff - 13'd1);
        end else begin
            n_res.last_row = w_lr_raw[11:0];
        end

        n_res.first_column = w_fc_raw[16] ? 16'sd0 : w_fc_raw[15:0];

        if (w_lc_raw >= $signed({4'b0000, w_width_eff})) begin
            n_res.last_column = $signed(16'(w_width_eff - 13'd1));
        end else begin
            n_res.last_column = w_lc_raw[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2 <= n_res;
        end
    end

endmodule

FILE: hdl/scp_checker.sv
// port-level checker for the sprite projection core, bound to the top level
// depends on scp_pkg and sprite_camera_projection_core_assert.svh
`include "sprite_camera_projection_core_assert.svh"

module scp_checker
    import scp_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_s_axis_tready,
    input logic                    o_m_axis_tvalid,
    input logic                    i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    // a stalled result beat stays put
    `SCP_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat changed under stall")

    // input side only backs off after the output side stalled
    `SCP_ASSERT_RST(a_ready_cause, i_clk, i_rst_n, !o_s_axis_tready |-> $past(o_m_axis_tvalid && !i_m_axis_tready), "input stalled without output back-pressure")

    // visible flag agrees with the sign of depth
    `SCP_ASSERT_RST(a_visible, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[32] == (!o_m_axis_tdata[31] && (o_m_axis_tdata[31:0] != 32'd0))), "visible flag does not match depth")

    // first row never above half the tallest screen, padding stays clear
    `SCP_ASSERT_RST(a_row_pad, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[108:97] <= 12'd2048) && (o_m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)] == '0), "row bound or padding out of range")

    // nothing comes out right after reset
    `SCP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result beat right after reset")

endmodule

bind sprite_camera_projection_core scp_checker u_scp_checker (.*);

FILE: test/sprite_camera_projection_core_checker.sv
`timescale 1ns / 1ps
// scoreboard for the sprite camera projection core: predicts each result beat
// from the accepted input beat and the tracked screen registers; uses scp_pkg
module sprite_camera_projection_core_checker
    import scp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [RES_W-1:0]        i_cfg_wdata,
    input  logic                    i_s_axis_tvalid,
    input  logic                    i_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                    i_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  i_m_axis_tdata,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_beats_checked
);

    // limits of a 32-bit signed depth, at full working width
    localparam logic signed [127:0] DEPTH_MAX = 128'sd2147483647;
    localparam logic signed [127:0] DEPTH_MIN = -128'sd2147483648;

    // sprite_x in the lowest bits, plane_y in the highest
    typedef struct packed {
        logic signed [31:0] plane_y;
        logic signed [31:0] plane_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] player_y;
        logic signed [31:0] player_x;
        logic signed [31:0] sprite_y;
        logic signed [31:0] sprite_x;
    } t_scene;

    logic [RES_W-1:0] width_reg, height_reg;
    t_result          projections_due[$];

    function automatic logic signed [127:0] usable_res(logic [RES_W-1:0] v);
        if (v < RES_MIN) return 1;
        if (v > RES_MAX) return 4096;
        return v;
    endfunction

    function automatic logic signed [127:0] mag(logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_result project_sprite(t_scene s, logic [RES_W-1:0] wr,
                                               logic [RES_W-1:0] hr);
        logic signed [127:0] w, h, rx, ry, det, nx, ny, q, dep, ctr, sz, half;
        logic signed [127:0] fc, lc, fr, lr;
        t_result r;
        w  = usable_res(wr);
        h  = usable_res(hr);
        rx = s.sprite_x - s.player_x;
        ry = s.sprite_y - s.player_y;
        det = s.plane_x * s.dir_y - s.dir_x * s.plane_y;
        nx  = s.dir_y * rx - s.dir_x * ry;
        ny  = s.plane_x * ry - s.plane_y * rx;
        // singular camera gives zero depth
        if (det == 0) begin
            dep = 0;
        end else begin
            q = (ny * (128'sd1 <<< FRAC_BITS)) / det;
            dep = (q > DEPTH_MAX) ? DEPTH_MAX : (q < DEPTH_MIN) ? DEPTH_MIN : q;
        end
        // sprite on the camera plane: size and centre saturate
        if (ny == 0) begin
            ctr = (nx < 0) ? -32768 : 32767;
            sz  = 65535;
        end else begin
            q   = ((nx + ny) * (w / 2)) / ny;
            ctr = (q > 32767) ? 32767 : (q < -32768) ? -32768 : q;
            q   = mag(det * h) / mag(ny);
            sz  = (q > 65535) ? 65535 : q;
        end
        half = sz / 2;
        fr = h / 2 - half;
        if (fr < 0) fr = 0;
        lr = h / 2 + half;
        if (lr >= h) lr = h - 1;
        fc = ctr - half;
        if (fc < 0) fc = 0;
        lc = ctr + half;
        if (lc >= w) lc = w - 1;
        r.depth         = dep[31:0];
        r.visible       = dep > 0;
        r.center_column = ctr[15:0];
        r.sprite_size   = sz[15:0];
        r.first_column  = fc[15:0];
        r.last_column   = lc[15:0];
        r.first_row     = fr[11:0];
        r.last_row      = lr[11:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            projections_due.delete();
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_SCREEN_WIDTH)  width_reg  <= i_cfg_wdata;
            if (i_cfg_we && i_cfg_index == CFG_SCREEN_HEIGHT) height_reg <= i_cfg_wdata;
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[$bits(t_result)-1:0];
                if (projections_due.size() == 0) begin
                    $display("%0t unexpected result beat %0h", $realtime, got);
                    o_fail_count++;
                end else begin
                    want = projections_due.pop_front();
                    check_field("depth",         want.depth,         got.depth);
                    check_field("visible",       want.visible,       got.visible);
                    check_field("center_column", want.center_column, got.center_column);
                    check_field("sprite_size",   want.sprite_size,   got.sprite_size);
                    check_field("first_column",  want.first_column,  got.first_column);
                    check_field("last_column",   want.last_column,   got.last_column);
                    check_field("first_row",     want.first_row,     got.first_row);
                    check_field("last_row",      want.last_row,      got.last_row);
                    check_field("padding", 0, i_m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)]);
                end
                o_beats_checked++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                projections_due.push_back(project_sprite(i_s_axis_tdata, width_reg,
                                                         height_reg));
        end
        o_pending = projections_due.size();
    end

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_beats_checked = 0;
    end

endmodule

FILE: test/sprite_camera_projection_core_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the sprite camera projection core
// uses scp_pkg, the core and sprite_camera_projection_core_checker
module sprite_camera_projection_core_tb;
    import scp_pkg::*;

    localparam int ONE       = 65536;        // 1.0 in Q16.16
    localparam int LATENCY   = 42;
    localparam int CYCLE_CAP = 2000000;
    localparam int RANDOM_N  = 1600;
    localparam int LONG_HOLD = 400;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_SCREEN_WIDTH;
    logic [RES_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;  // sprite_x .. plane_y, 32 bits each, low first
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;       // depth, visible, center, size, cols, rows

    int  fail_count, pending, beats_checked;
    int  cycle_count = 0;
    int  hold_off = 0;        // long receiver stall, counted down by the receiver
    int  hold_req = 0;        // bumped by the stimulus to ask for a long stall
    int  hold_seen = 0;       // last request the receiver picked up
    bit  steady = 1'b0;       // no random gaps on either side while set
    int  sent = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sprite_camera_projection_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    sprite_camera_projection_core_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // receiver: random back pressure plus the long hold-off when asked
    always @(posedge i_clk) begin
        int stall;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            m_tready  <= 1'b0;
            hold_off  <= LONG_HOLD - 1;
            hold_seen <= hold_req;
        end else if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else begin
            stall = gap_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                hold_off <= stall - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] scene(int sx, int sy, int px, int py,
                                                    int dx, int dy, int plx, int ply);
        return {ply, plx, dy, dx, py, px, sy, sx};
    endfunction

    // offer one beat and hold it until accepted, then maybe idle
    task automatic send_beat(logic [IN_TDATA_W-1:0] d);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        sent++;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RES_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_screen(logic [RES_W-1:0] w, logic [RES_W-1:0] h);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
    endtask

    // a plausible camera: unit-ish direction and perpendicular plane, nearby sprite
    function automatic logic [IN_TDATA_W-1:0] game_scene();
        int px, py, dx, dy, k;
        px = $urandom_range(0, 64 * ONE);
        py = $urandom_range(0, 64 * ONE);
        dx = int'($urandom_range(0, 2 * ONE)) - ONE;
        dy = int'($urandom_range(0, 2 * ONE)) - ONE;
        k  = $urandom_range(1, 4);
        if ($urandom_range(0, 19) == 0) begin
            // sprite right on the camera plane, or very close to it
            return scene(px + dy * k / 2, py - dx * k / 2, px, py, dx, dy,
                         dy * 2 / 3, -dx * 2 / 3);
        end
        return scene(px + int'($urandom_range(0, 40 * ONE)) - 20 * ONE,
                     py + int'($urandom_range(0, 40 * ONE)) - 20 * ONE,
                     px, py, dx, dy, (dy * k) / 3, -(dx * k) / 3);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] noise_scene();
        logic [IN_TDATA_W-1:0] d;
        for (int i = 0; i < 8; i++) d[32*i +: 32] = $urandom();
        return d;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_beat(($urandom_range(0, 3) == 0) ? noise_scene() : game_scene());
    endtask

    initial begin
        int mn, mx;
        mn = 32'sh8000_0000;
        mx = 32'sh7fff_ffff;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset resolution
        steady = 1'b1;
        send_beat(scene(0, 0, 0, 0, 0, 0, 0, 0));                 // everything zero
        send_beat(scene(mx, mx, mn, mn, mx, mx, mx, mx));         // singular, huge offsets
        send_beat(scene(mn, mx, mx, mn, mn, mx, mx, mn));
        send_beat(scene(mn, mn, mn, mn, mn, mn, mn, mn));
        send_beat(scene(mx, mn, mx, mn, mn, mx, mx, mn));
        send_beat(scene(-1, -1, 0, 0, mn, mx, mn, mx));
        // usual camera facing -x with a 0.66 plane
        send_beat(scene(-5 * ONE, 0, 0, 0, -ONE, 0, 0, 43254));   // straight ahead
        send_beat(scene(5 * ONE, 0, 0, 0, -ONE, 0, 0, 43254));    // behind
        send_beat(scene(-ONE / 100, ONE, 0, 0, -ONE, 0, 0, 43254)); // tiny depth
        send_beat(scene(0, ONE, 0, 0, -ONE, 0, 0, 43254));        // on the plane, nx > 0
        send_beat(scene(0, -ONE, 0, 0, -ONE, 0, 0, 43254));       // on the plane, nx < 0
        send_beat(scene(-3 * ONE, 2 * ONE, 0, 0, ONE, 0, ONE, 0)); // singular, ny nonzero
        send_beat(scene(-200 * ONE, 7 * ONE, 0, 0, -ONE, 0, 0, 43254)); // far, tiny size
        send_beat(scene(-ONE, 30 * ONE, 0, 0, -ONE, 0, 0, 43254)); // far off to the side
        send_beat(scene(-2 * ONE, ONE / 2, 0, 0, -ONE, 0, 0, -43254)); // mirrored plane
        steady = 1'b0;
        drain();

        // extremes of the screen registers, out-of-range values too
        set_screen(13'd1, 13'd1);
        for (int i = 0; i < 12; i++) send_beat(game_scene());
        drain();
        set_screen(13'd4096, 13'd4096);
        random_phase(60);
        drain();
        set_screen(13'd0, 13'd8191);
        random_phase(60);
        drain();
        set_screen(13'd8191, 13'd0);
        random_phase(60);
        drain();

        // long receiver hold-off while the sender keeps pushing
        set_screen(WIDTH_RST, HEIGHT_RST);
        steady = 1'b1;
        hold_req++;
        random_phase(120);
        steady = 1'b0;
        drain();

        // random resolutions, with the sender pausing for the drain each time
        for (int ph = 0; ph < 8; ph++) begin
            set_screen(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
            random_phase(RANDOM_N / 8);
            drain();
        end

        $display("sent %0d sprite beats, checked %0d projections over several screen sizes",
                 sent, beats_checked);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
